// File: design/vct_pkg.sv
// Shared types and constants for the view coordinate transform.
// Holds the sine polynomial coefficients, register indexes, the divider
// stage record and the trigonometry status record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vct_pkg;

    localparam logic [31:0] SC1 = 32'd1686629713;
    localparam logic [31:0] SC3 = 32'd693598668;
    localparam logic [31:0] SC5 = 32'd85569278;
    localparam logic [31:0] SC7 = 32'd5026991;
    localparam logic [31:0] SC9 = 32'd172272;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic signed [17:0] UNITY = 18'sd65536;
    localparam logic [15:0] ZOOM_MIN = 16'd26;

    localparam logic [2:0] REG_CAM_X       = 3'd0;
    localparam logic [2:0] REG_CAM_Y       = 3'd1;
    localparam logic [2:0] REG_ZOOM        = 3'd2;
    localparam logic [2:0] REG_ANGLE       = 3'd3;
    localparam logic [2:0] REG_VIEW_WIDTH  = 3'd4;
    localparam logic [2:0] REG_VIEW_HEIGHT = 3'd5;

    localparam logic [2:0] STEP_SQ   = 3'd0;
    localparam logic [2:0] STEP_C7   = 3'd1;
    localparam logic [2:0] STEP_C5   = 3'd2;
    localparam logic [2:0] STEP_C3   = 3'd3;
    localparam logic [2:0] STEP_C1   = 3'd4;
    localparam logic [2:0] STEP_LAST = 3'd5;

    localparam int DIV_BITS = 4;
    localparam int DST      = 11;
    localparam int DIVW     = DIV_BITS * DST;
    localparam int REMW     = 17;

    typedef enum logic {
        SC_IDLE,
        SC_RUN
    } sc_state_t;

    typedef struct packed {
        logic [DIVW-1:0] num;
        logic [REMW-1:0] rem;
    } divs_t;

    typedef struct packed {
        logic               busy;
        logic signed [17:0] sn;
        logic signed [17:0] cs;
    } trig_t;

    function automatic logic [31:0] coef(input logic [2:0] step);
        logic [31:0] c;
        case (step)
            STEP_C7: c = SC7;
            STEP_C5: c = SC5;
            STEP_C3: c = SC3;
            STEP_C1: c = SC1;
            default: c = SC1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/vct_sincos.sv
// Sine and cosine of the rotation angle, recomputed after each angle write.
// One shared 32 by 32 multiplier steps through a ninth-order polynomial.
// Depends on vct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vct_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output vct_pkg::trig_t             trig
);
    import vct_pkg::*;

    localparam int QB = ANGLE_BITS - 2;

    sc_state_t          state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    logic               ph_reg, ph_next;
    logic [1:0]         quad_reg, quad_next;
    logic [30:0]        t_reg, t_next;
    logic [30:0]        t2_reg, t2_next;
    logic [31:0]        p_reg, p_next;
    logic [16:0]        s0_reg, s0_next;
    logic signed [17:0] sn_reg, sn_next;
    logic signed [17:0] cs_reg, cs_next;

    logic [31:0] opa, opb;
    logic [63:0] mul;
    logic [33:0] hi;
    logic [34:0] s_sum;
    logic [20:0] s_full;
    logic [16:0] s_cap;
    logic signed [17:0] s0_s, c_s;

    always_comb
    begin
        if (step_reg == STEP_SQ)
        begin
            opa = {1'b0, t_reg};
            opb = {1'b0, t_reg};
        end
        else if (step_reg == STEP_C7)
        begin
            opa = SC9;
            opb = {1'b0, t2_reg};
        end
        else if (step_reg == STEP_LAST)
        begin
            opa = p_reg;
            opb = {1'b0, t_reg};
        end
        else
        begin
            opa = p_reg;
            opb = {1'b0, t2_reg};
        end
        mul    = 64'(opa) * 64'(opb);
        hi     = mul[63:30];
        s_sum  = 35'(hi) + 35'(14'h2000);
        s_full = s_sum[34:14];
        s_cap  = (s_full > 21'd65536) ? 17'd65536 : s_full[16:0];
        s0_s   = $signed({1'b0, s0_reg});
        c_s    = $signed({1'b0, s_cap});
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ph_next    = ph_reg;
        quad_next  = quad_reg;
        t_next     = t_reg;
        t2_next    = t2_reg;
        p_next     = p_reg;
        s0_next    = s0_reg;
        sn_next    = sn_reg;
        cs_next    = cs_reg;
        if (start)
        begin
            if (angle == '0)
            begin
                state_next = SC_IDLE;
                sn_next    = '0;
                cs_next    = UNITY;
            end
            else
            begin
                state_next = SC_RUN;
                step_next  = STEP_SQ;
                ph_next    = 1'b0;
                quad_next  = angle[ANGLE_BITS-1 -: 2];
                t_next     = 31'(angle[QB-1:0]) << (30 - QB);
            end
        end
        else
        begin
            case (state_reg)
                SC_IDLE:
                begin
                    state_next = SC_IDLE;
                end
                SC_RUN:
                begin
                    if (step_reg == STEP_SQ)
                    begin
                        t2_next   = hi[30:0];
                        step_next = step_reg + 3'd1;
                    end
                    else if (step_reg != STEP_LAST)
                    begin
                        p_next    = coef(step_reg) - hi[31:0];
                        step_next = step_reg + 3'd1;
                    end
                    else if (!ph_reg)
                    begin
                        s0_next   = s_cap;
                        ph_next   = 1'b1;
                        t_next    = ONE_Q30 - t_reg;
                        step_next = STEP_SQ;
                    end
                    else
                    begin
                        state_next = SC_IDLE;
                        case (quad_reg)
                            2'd0:
                            begin
                                sn_next = s0_s;
                                cs_next = c_s;
                            end
                            2'd1:
                            begin
                                sn_next = c_s;
                                cs_next = -s0_s;
                            end
                            2'd2:
                            begin
                                sn_next = -s0_s;
                                cs_next = -c_s;
                            end
                            default:
                            begin
                                sn_next = -c_s;
                                cs_next = s0_s;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_next = SC_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            step_reg  <= STEP_SQ;
            ph_reg    <= 1'b0;
            sn_reg    <= '0;
            cs_reg    <= UNITY;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ph_reg    <= ph_next;
            sn_reg    <= sn_next;
            cs_reg    <= cs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
        t_reg    <= t_next;
        t2_reg   <= t2_next;
        p_reg    <= p_next;
        s0_reg   <= s0_next;
    end

    assign trig.busy = (state_reg == SC_RUN);
    assign trig.sn   = sn_reg;
    assign trig.cs   = cs_reg;

endmodule

`default_nettype wire

// File: design/view_coordinate_transform_top.sv
// Top level of the view coordinate transform: configuration registers and
// the point pipeline (offset, zoom, rotation, rounding, division, saturation).
// Depends on vct_pkg and vct_sincos.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  mode, in_x, in_y
// out       output     out_valid / out_stall out_x, out_y
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One point enters per cycle while in_stall is low.
// The pipeline is built from eight arithmetic stages and the 11-stage divider,
// which retires four quotient bits per stage.
// An angle write holds in_stall high in its own cycle, and a nonzero angle
// keeps it high while the shared multiplier evaluates sine and cosine.
// Reset loads the register defaults; no clearing pass is needed.
// A stalled result freezes the whole pipeline, and nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module view_coordinate_transform_top #(
    parameter int FRAC_BITS  = 12,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y
);
    import vct_pkg::*;

    localparam int DW = 34;
    localparam int PW = 51;
    localparam int VW = 44;
    localparam int MW = 62;
    localparam int SW = 63;
    localparam int RW = 45;
    localparam int FW = 47;
    localparam int NS = DST + 8;

    logic signed [31:0] cam_x_reg, cam_y_reg;
    logic [15:0]        zoom_reg;
    logic [15:0]        angle_reg;
    logic [12:0]        view_w_reg, view_h_reg;

    logic               ang_wr;
    logic               en;
    logic [15:0]        zc;
    logic signed [DW-1:0] half [2];
    logic signed [31:0]   cam [2];
    logic signed [31:0]   pin [2];
    trig_t              trig;

    logic [NS-1:0]        vld_reg;
    logic                 mode_reg [NS];
    logic signed [DW-1:0] d1_reg [2];
    logic signed [DW-1:0] d2_reg [2];
    logic signed [PW-1:0] p_reg [2];
    logic signed [VW-1:0] v_reg [2];
    logic signed [MW-1:0] pc_reg [2];
    logic signed [MW-1:0] ps_reg [2];
    logic signed [SW-1:0] s_reg [2];
    logic signed [RW-1:0] r_reg [2];
    divs_t                dv_reg [DST+1][2];
    logic signed [FW-1:0] pre_reg [DST+1][2];
    logic                 neg_reg [DST+1][2];
    logic signed [31:0]   out_x_reg, out_y_reg;

    logic signed [RW-1:0] mag [2];
    logic signed [FW-1:0] qs [2];
    logic signed [FW-1:0] fin [2];
    logic signed [31:0]   sat [2];

    function automatic divs_t dstep(input divs_t s, input logic [15:0] z);
        divs_t          o;
        logic [REMW-1:0] t;
        o = s;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            t = {o.rem[REMW-2:0], o.num[DIVW-1]};
            if (t >= {1'b0, z})
            begin
                o.rem = t - {1'b0, z};
                o.num = {o.num[DIVW-2:0], 1'b1};
            end
            else
            begin
                o.rem = t;
                o.num = {o.num[DIVW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            zoom_reg   <= 16'd256;
            angle_reg  <= '0;
            view_w_reg <= 13'd1024;
            view_h_reg <= 13'd768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAM_X:       cam_x_reg  <= $signed(cfg_data);
                REG_CAM_Y:       cam_y_reg  <= $signed(cfg_data);
                REG_ZOOM:        zoom_reg   <= cfg_data[15:0];
                REG_ANGLE:       angle_reg  <= cfg_data[15:0];
                REG_VIEW_WIDTH:  view_w_reg <= cfg_data[12:0];
                REG_VIEW_HEIGHT: view_h_reg <= cfg_data[12:0];
                default:         view_h_reg <= view_h_reg;
            endcase
        end
    end

    assign ang_wr = cfg_we && (cfg_index == REG_ANGLE);

    vct_sincos #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_sincos (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ang_wr),
        .angle (cfg_data[ANGLE_BITS-1:0]),
        .trig  (trig)
    );

    assign zc      = (zoom_reg < ZOOM_MIN) ? ZOOM_MIN : zoom_reg;
    assign half[0] = $signed(DW'(view_w_reg) << (FRAC_BITS - 1));
    assign half[1] = $signed(DW'(view_h_reg) << (FRAC_BITS - 1));
    assign cam[0]  = cam_x_reg;
    assign cam[1]  = cam_y_reg;
    assign pin[0]  = in_x;
    assign pin[1]  = in_y;

    assign en        = !(vld_reg[NS-1] && out_stall);
    assign in_stall  = !en || trig.busy || ang_wr;
    assign out_valid = vld_reg[NS-1];
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            mag[c] = r_reg[c][RW-1] ? -r_reg[c] : r_reg[c];
            qs[c]  = $signed(FW'(dv_reg[DST][c].num));
            if (mode_reg[NS-2])
            begin
                fin[c] = (neg_reg[DST][c] ? -qs[c] : qs[c]) + FW'(cam[c]);
            end
            else
            begin
                fin[c] = pre_reg[DST][c];
            end
            if (fin[c][FW-1:31] == '0 || fin[c][FW-1:31] == '1)
            begin
                sat[c] = fin[c][31:0];
            end
            else if (fin[c][FW-1])
            begin
                sat[c] = 32'sh8000_0000;
            end
            else
            begin
                sat[c] = 32'sh7fff_ffff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid && !in_stall};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg[0] <= mode;
            for (int k = 1; k < NS; k++)
            begin
                mode_reg[k] <= mode_reg[k-1];
            end
            for (int c = 0; c < 2; c++)
            begin
                d1_reg[c] <= mode ? DW'(pin[c]) - half[c] : DW'(pin[c]) - DW'(cam[c]);
                d2_reg[c] <= d1_reg[c];
                p_reg[c]  <= d1_reg[c] * $signed({1'b0, zc});
                v_reg[c]  <= mode_reg[1] ? VW'(d2_reg[c])
                                         : VW'((p_reg[c] + $signed(PW'(128))) >>> 8);
                pc_reg[c] <= v_reg[c] * trig.cs;
                ps_reg[c] <= v_reg[c] * trig.sn;
                r_reg[c]  <= mode_reg[4] ? RW'((s_reg[c] + $signed(SW'(128))) >>> 8)
                                         : RW'((s_reg[c] + $signed(SW'(32768))) >>> 16);
                pre_reg[0][c] <= FW'(r_reg[c]) + FW'(half[c]);
                neg_reg[0][c] <= r_reg[c][RW-1];
                dv_reg[0][c]  <= {DIVW'($unsigned(mag[c])) + DIVW'(zc[15:1]),
                                  {REMW{1'b0}}};
                for (int k = 1; k <= DST; k++)
                begin
                    dv_reg[k][c]  <= dstep(dv_reg[k-1][c], zc);
                    pre_reg[k][c] <= pre_reg[k-1][c];
                    neg_reg[k][c] <= neg_reg[k-1][c];
                end
            end
            s_reg[0]  <= mode_reg[3] ? pc_reg[0] + ps_reg[1] : pc_reg[0] - ps_reg[1];
            s_reg[1]  <= mode_reg[3] ? pc_reg[1] - ps_reg[0] : ps_reg[0] + pc_reg[1];
            out_x_reg <= sat[0];
            out_y_reg <= sat[1];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && out_stall) |=> $stable(vld_reg))
    else $error("Pipeline advanced while the result transaction was stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        trig.busy |-> in_stall)
    else $error("Input transaction taken while sine and cosine were being computed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-2] |-> (dv_reg[DST][0].rem < {1'b0, zc} && dv_reg[DST][1].rem < {1'b0, zc}))
    else $error("Divider remainder is not below the zoom divisor.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!trig.busy && angle_reg[ANGLE_BITS-1:0] == '0 && !$past(ang_wr))
            |-> (trig.sn == '0 && trig.cs == UNITY))
    else $error("Zero angle does not give an identity rotation.");

endmodule

`default_nettype wire
